// File: sv/soco_pkg.sv
package soco_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned PROD_W  = 2 * COORD_W;
	localparam int unsigned AXES    = 3;
	localparam int unsigned MAX_RES = 4;

	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_CENTER_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
	} seg_item_t;

	typedef struct packed {
		logic [2:0] octant;
		logic       last_of_run;
	} oct_item_t;

endpackage

// File: sv/segment_octant_crossing_order_unit.sv
// Segment octant crossing order.
// in_valid/in_ready/in_item take one segment (start and end point) per item.
// out_valid/out_ready/out_item give the octants the segment passes through
// around the centre, start octant first, one to four items per segment; the
// final one carries last_of_run.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the centre registers
// (0 x, 1 y, 2 z); cfg_ready is always high and an index of 3 is dropped.
// Each segment passes four registered stages in order: input, axis
// times, cross products, result list. Throughput: one segment per
// cycle when each yields one result and the receiver does not stall;
// otherwise a segment holds the result stage until all its results
// (up to four) are taken, since the result port moves one octant per
// cycle while out_ready is high.
// Reset clears all stage valids and sets the centre to the origin.
// When the receiver stalls, the result list holds and the stages behind it
// fill up; in_ready falls once all four stages hold an item.
module segment_octant_crossing_order_unit
	import soco_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  seg_item_t                 in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output oct_item_t                 out_item,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic signed [COORD_W-1:0] cfg_data
);

	logic signed [COORD_W-1:0] center_q [AXES];

	logic             v_s1;
	seg_item_t        item_s1;

	logic             v_s2;
	logic [2:0]       oct0_s2;
	logic [2:0]       oct1_s2;
	logic [2:0]       ok_s2;
	logic [COORD_W-1:0] n_s2 [AXES];
	logic [COORD_W-1:0] d_s2 [AXES];

	logic             v_s3;
	logic [2:0]       oct0_s3;
	logic             cross_s3;
	logic [2:0]       ok_s3;
	logic [PROD_W-1:0] pa_s3 [AXES];
	logic [PROD_W-1:0] pb_s3 [AXES];

	logic             v_s4;
	logic [2:0]       list_s4 [MAX_RES];
	logic [1:0]       last_s4;
	logic [1:0]       idx_q;

	logic ready_s2, ready_s3, ready_s4, done_s4;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) center_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	assign done_s4  = v_s4 && out_ready && (idx_q == last_s4);
	assign ready_s4 = !v_s4 || done_s4;
	assign ready_s3 = !v_s3 || ready_s4;
	assign ready_s2 = !v_s2 || ready_s3;
	assign in_ready = !v_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
			if (ready_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
	end

	// stage 2: octants and normalised crossing times
	logic signed [COORD_W-1:0] s_c [AXES];
	logic signed [COORD_W-1:0] e_c [AXES];
	logic [2:0]                oct0_c, oct1_c, ok_c;
	logic [COORD_W-1:0]        n_c [AXES];
	logic [COORD_W-1:0]        d_c [AXES];

	always_comb begin
		logic signed [COORD_W:0] n17;
		logic signed [COORD_W:0] d17;
		s_c[0] = item_s1.start_x;
		s_c[1] = item_s1.start_y;
		s_c[2] = item_s1.start_z;
		e_c[0] = item_s1.end_x;
		e_c[1] = item_s1.end_y;
		e_c[2] = item_s1.end_z;
		for (int i = 0; i < AXES; i++) begin
			oct0_c[i] = (s_c[i] >= center_q[i]);
			oct1_c[i] = (e_c[i] >= center_q[i]);
			n17 = {center_q[i][COORD_W-1], center_q[i]} - {s_c[i][COORD_W-1], s_c[i]};
			d17 = {e_c[i][COORD_W-1], e_c[i]} - {s_c[i][COORD_W-1], s_c[i]};
			if (d17 < 0) begin
				n17 = -n17;
				d17 = -d17;
			end
			ok_c[i] = (d17 != 0) && (n17 >= 0) && (n17 <= d17);
			n_c[i]  = n17[COORD_W-1:0];
			d_c[i]  = d17[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			oct0_s2 <= oct0_c;
			oct1_s2 <= oct1_c;
			ok_s2   <= ok_c;
			for (int i = 0; i < AXES; i++) begin
				n_s2[i] <= n_c[i];
				d_s2[i] <= d_c[i];
			end
		end
	end

	// stage 3: cross products, pair 0 = x/y, 1 = x/z, 2 = y/z
	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			oct0_s3  <= oct0_s2;
			cross_s3 <= (oct0_s2 != oct1_s2);
			ok_s3    <= ok_s2;
			pa_s3[0] <= PROD_W'(n_s2[0]) * PROD_W'(d_s2[1]);
			pb_s3[0] <= PROD_W'(n_s2[1]) * PROD_W'(d_s2[0]);
			pa_s3[1] <= PROD_W'(n_s2[0]) * PROD_W'(d_s2[2]);
			pb_s3[1] <= PROD_W'(n_s2[2]) * PROD_W'(d_s2[0]);
			pa_s3[2] <= PROD_W'(n_s2[1]) * PROD_W'(d_s2[2]);
			pb_s3[2] <= PROD_W'(n_s2[2]) * PROD_W'(d_s2[1]);
		end
	end

	// stage 4: flip order
	logic [2:0] lt [AXES];
	logic [2:0] list_c [MAX_RES];
	logic [1:0] last_c;

	always_comb begin
		logic [2:0] avail;
		logic [2:0] cur;
		logic [1:0] pick;
		logic       found;
		logic       smallest;
		logic       stop;
		lt[0] = {pa_s3[1] < pb_s3[1], pa_s3[0] < pb_s3[0], 1'b1};
		lt[1] = {pa_s3[2] < pb_s3[2], 1'b1, pb_s3[0] < pa_s3[0]};
		lt[2] = {1'b1, pb_s3[2] < pa_s3[2], pb_s3[1] < pa_s3[1]};
		avail  = ok_s3;
		cur    = oct0_s3;
		stop   = !cross_s3;
		last_c = 2'd0;
		for (int k = 0; k < MAX_RES; k++) list_c[k] = oct0_s3;
		for (int r = 0; r < AXES; r++) begin
			found = 1'b0;
			pick  = 2'd0;
			for (int i = 0; i < AXES; i++) begin
				smallest = avail[i];
				for (int j = 0; j < AXES; j++) begin
					if (j != i && avail[j] && !lt[i][j]) smallest = 1'b0;
				end
				if (smallest && !found) begin
					found = 1'b1;
					pick  = 2'(i);
				end
			end
			if (!stop && found) begin
				avail[pick]  = 1'b0;
				cur[pick]    = !cur[pick];
				last_c       = 2'(r + 1);
				list_c[r+1]  = cur;
			end else begin
				stop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && v_s3) begin
			last_s4 <= last_c;
			for (int k = 0; k < MAX_RES; k++) list_s4[k] <= list_c[k];
		end
	end

	// result serialiser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (v_s4 && out_ready) begin
			idx_q <= done_s4 ? 2'd0 : idx_q + 2'd1;
		end
	end

	assign out_valid            = v_s4;
	assign out_item.octant      = list_s4[idx_q];
	assign out_item.last_of_run = (idx_q == last_s4);

endmodule
